// File: hdl/table_quadratic_sqrt_approx_macros.svh
// Assertion macros for the square root approximation block.
`ifndef TABLE_QUADRATIC_SQRT_APPROX_MACROS_SVH
`define TABLE_QUADRATIC_SQRT_APPROX_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TQSA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tqsa: implication check failed");
// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TQSA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tqsa: next-cycle check failed");
`else
`define TQSA_ASSERT_IMP(lbl, ante, cons)
`define TQSA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: hdl/tqsa_pkg.sv
// Types and constants for the square root approximation block.
package tqsa_pkg;

  localparam int unsigned FRAC_BITS  = 23;
  localparam int unsigned INDEX_BITS = 8;
  localparam int unsigned CORR_BITS  = 10;
  localparam int unsigned LOW_BITS   = 15;

  localparam int unsigned OPERAND_W  = 25;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned CURVE_W    = 8;
  localparam int unsigned STORE_DEPTH = 512;
  localparam int unsigned ADDR_W     = 9;
  localparam int unsigned QSHIFT     = 18;

  // low field is one bit wider in the upper half range
  localparam int unsigned LOW_W   = LOW_BITS + 1;
  localparam int unsigned PROD_W  = WORD_W + LOW_W;
  localparam int unsigned Z_W     = 2 * CORR_BITS;
  localparam int unsigned QPROD_W = Z_W + CURVE_W;

  localparam int unsigned IN_TDATA_W  = 112;
  localparam int unsigned OUT_TDATA_W = 32;

  typedef enum logic {
    REQ_ROOT  = 1'b0,
    REQ_WRITE = 1'b1
  } req_e;

  typedef struct packed {
    logic [CURVE_W-1:0] curve;
    logic [WORD_W-1:0]  slope;
    logic [WORD_W-1:0]  base;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

// File: hdl/tqsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tqsa_ram #(
  parameter int unsigned WIDTH = 72,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/table_quadratic_sqrt_approx.sv
// Table-driven square root approximation with quadratic interpolation.
// Takes one word per cycle while the output side is ready and returns one root per
// compute word; table-write words (tuser = 1) load one entry of the base, slope and
// curvature tables and give no output. The rate comes from a four-stage pipeline:
// table read, the two products, the curvature product with the slope shift, and the
// final sum into the output register; each stage moves on its own, so bubbles close
// up under back-pressure. The tables are not cleared at reset: an entry must be
// written before a root that uses it is asked for. Entry index bit 8 selects the
// [2,4) half range.
`include "table_quadratic_sqrt_approx_macros.svh"

module table_quadratic_sqrt_approx (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // operand[24:0], entry_index[33:25], base_word[65:34], slope_word[97:66],
  // curve_word[105:98], zero[111:106]
  input  logic [111:0] s_axis_tdata,
  // req_type[0]
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // root[31:0]
  output logic [31:0]  m_axis_tdata
);

  localparam int unsigned LowB   = tqsa_pkg::LOW_BITS;
  localparam int unsigned CorrB  = tqsa_pkg::CORR_BITS;
  localparam int unsigned IdxB   = tqsa_pkg::INDEX_BITS;
  localparam int unsigned WordW  = tqsa_pkg::WORD_W;
  localparam int unsigned LowW   = tqsa_pkg::LOW_W;
  localparam int unsigned ProdW  = tqsa_pkg::PROD_W;
  localparam int unsigned ZW     = tqsa_pkg::Z_W;
  localparam int unsigned QProdW = tqsa_pkg::QPROD_W;
  localparam int unsigned CurveW = tqsa_pkg::CURVE_W;
  localparam int unsigned AddrW  = tqsa_pkg::ADDR_W;

  // input word fields
  logic [tqsa_pkg::OPERAND_W-1:0] operand;
  logic [AddrW-1:0]               entry_index;
  tqsa_pkg::entry_t               wr_entry;
  tqsa_pkg::req_e                 req_type;

  assign operand        = s_axis_tdata[24:0];
  assign entry_index    = s_axis_tdata[33:25];
  assign wr_entry.base  = s_axis_tdata[65:34];
  assign wr_entry.slope = s_axis_tdata[97:66];
  assign wr_entry.curve = s_axis_tdata[105:98];
  assign req_type       = tqsa_pkg::req_e'(s_axis_tuser[0]);

  // per-stage ready
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  logic in_fire, wr_fire;
  assign in_fire = s_axis_tvalid && rdy1;
  assign wr_fire = in_fire && (req_type == tqsa_pkg::REQ_WRITE);

  // stage 0 decode: half range, table address, low field, correction bits
  logic              half;
  logic [AddrW-1:0]  rd_addr;
  logic [LowW-1:0]   low_d;
  logic [CorrB-1:0]  u_d;

  assign half = operand[tqsa_pkg::FRAC_BITS+1];

  always_comb begin
    if (half) begin
      rd_addr = {1'b1, operand[LowB+1 +: IdxB]};
      low_d   = operand[LowB:0];
      u_d     = operand[LowB+1-CorrB +: CorrB];
    end else begin
      rd_addr = {1'b0, operand[LowB +: IdxB]};
      low_d   = {1'b0, operand[LowB-1:0]};
      u_d     = operand[LowB-CorrB +: CorrB];
    end
  end

  tqsa_pkg::entry_t rd_entry;
  logic [tqsa_pkg::ENTRY_W-1:0] rd_word;

  tqsa_ram #(
    .WIDTH(tqsa_pkg::ENTRY_W),
    .DEPTH(tqsa_pkg::STORE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (wr_fire),
    .waddr_i(entry_index),
    .wdata_i(wr_entry),
    .re_i   (rdy1),
    .raddr_i(rd_addr),
    .rdata_o(rd_word)
  );

  assign rd_entry = tqsa_pkg::entry_t'(rd_word);

  // stage 1: table read in flight
  logic             half1_q;
  logic [LowW-1:0]  low1_q;
  logic [CorrB-1:0] u1_q;

  // stage 2: slope product, u*~u
  logic              half2_q;
  logic [ProdW-1:0]  prod2_q;
  logic [ZW-1:0]     z2_q;
  logic [WordW-1:0]  base2_q;
  logic [CurveW-1:0] curve2_q;

  // stage 3: shifted linear term, curvature product
  logic [WordW-1:0]  lin3_q;
  logic [QProdW-1:0] qprod3_q;
  logic [WordW-1:0]  base3_q;

  // stage 4: output register
  logic [WordW-1:0]  root4_q;

  logic [CorrB-1:0]  u1_inv;
  logic [WordW-1:0]  lin_d;
  logic [WordW-1:0]  root_d;

  assign u1_inv = ~u1_q;
  assign lin_d  = half2_q ? prod2_q[LowB+1 +: WordW] : prod2_q[LowB +: WordW];
  assign root_d = base3_q + lin3_q + WordW'(qprod3_q[QProdW-1:tqsa_pkg::QSHIFT]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_fire && (req_type == tqsa_pkg::REQ_ROOT);
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      half1_q <= half;
      low1_q  <= low_d;
      u1_q    <= u_d;
    end
    if (rdy2) begin
      half2_q  <= half1_q;
      prod2_q  <= ProdW'(rd_entry.slope) * ProdW'(low1_q);
      z2_q     <= ZW'(u1_q) * ZW'(u1_inv);
      base2_q  <= rd_entry.base;
      curve2_q <= rd_entry.curve;
    end
    if (rdy3) begin
      lin3_q   <= lin_d;
      qprod3_q <= QProdW'(z2_q) * QProdW'(curve2_q);
      base3_q  <= base2_q;
    end
    if (rdy4) begin
      root4_q <= root_d;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = root4_q;

  // table writes never start a pipeline word
  `TQSA_ASSERT_NXT(a_write_no_result, wr_fire, !v1_q)
  // input only blocks once every stage is full
  `TQSA_ASSERT_IMP(a_full_when_blocked, !s_axis_tready, v1_q && v2_q && v3_q && v4_q)
  // a stalled stage keeps its word
  `TQSA_ASSERT_NXT(a_stage1_holds, v1_q && !rdy2, v1_q && $stable(low1_q))
  `TQSA_ASSERT_NXT(a_stage2_holds, v2_q && !rdy3, v2_q && $stable(prod2_q))

endmodule

// File: sim/tqsa_root_checker.sv
// Scoreboard for the square root block: mirrors the tables and checks every root word.
`timescale 1ns / 100ps

module tqsa_root_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid_i,
  input  logic                             s_tready_i,
  input  logic [tqsa_pkg::IN_TDATA_W-1:0]  s_tdata_i,
  input  logic [0:0]                       s_tuser_i,
  input  logic                             m_tvalid_i,
  input  logic                             m_tready_i,
  input  logic [tqsa_pkg::OUT_TDATA_W-1:0] m_tdata_i,
  output int unsigned                      fail_count_o,
  output int unsigned                      roots_due_o,
  output int unsigned                      roots_checked_o
);

  localparam int unsigned WORD_W      = tqsa_pkg::WORD_W;
  localparam int unsigned CURVE_W     = tqsa_pkg::CURVE_W;
  localparam int unsigned STORE_DEPTH = tqsa_pkg::STORE_DEPTH;
  localparam int unsigned OPERAND_W   = tqsa_pkg::OPERAND_W;
  localparam int unsigned ADDR_W      = tqsa_pkg::ADDR_W;
  localparam int unsigned LOW_W       = tqsa_pkg::LOW_W;
  localparam int unsigned CORR_BITS   = tqsa_pkg::CORR_BITS;
  localparam int unsigned PROD_W      = tqsa_pkg::PROD_W;
  localparam int unsigned FRAC_BITS   = tqsa_pkg::FRAC_BITS;
  localparam int unsigned LOW_BITS    = tqsa_pkg::LOW_BITS;
  localparam int unsigned INDEX_BITS  = tqsa_pkg::INDEX_BITS;
  localparam int unsigned QSHIFT      = tqsa_pkg::QSHIFT;

  logic [WORD_W-1:0]  base_tab  [STORE_DEPTH];
  logic [WORD_W-1:0]  slope_tab [STORE_DEPTH];
  logic [CURVE_W-1:0] curve_tab [STORE_DEPTH];
  logic [WORD_W-1:0]  roots_q [$];
  int unsigned        fails   = 0;
  int unsigned        checked = 0;

  initial begin
    fail_count_o    = 0;
    roots_due_o     = 0;
    roots_checked_o = 0;
  end

  function automatic logic [WORD_W-1:0] predict_root(input logic [OPERAND_W-1:0] x);
    logic               half;
    int unsigned        lowpos;
    logic [ADDR_W-1:0]  idx;
    logic [LOW_W-1:0]   low;
    logic [CORR_BITS-1:0] u;
    logic [CORR_BITS-1:0] uc;
    logic [WORD_W-1:0]  z;
    logic [WORD_W-1:0]  q;
    logic [WORD_W-1:0]  lin;
    logic [PROD_W-1:0]  prod;
    half   = x[FRAC_BITS+1];
    lowpos = LOW_BITS + half;
    idx    = ADDR_W'(((x >> lowpos) & ((OPERAND_W'(1) << INDEX_BITS) - 1))
                     | (OPERAND_W'(half) << INDEX_BITS));
    low    = LOW_W'(x & ((OPERAND_W'(1) << lowpos) - 1));
    // u is the top of the low field; the low field is always wider than u here
    u      = CORR_BITS'(x >> (lowpos - CORR_BITS));
    uc     = ~u;
    z      = WORD_W'(u) * WORD_W'(uc);
    q      = (z * WORD_W'(curve_tab[idx])) >> QSHIFT;
    prod   = PROD_W'(slope_tab[idx]) * PROD_W'(low);
    lin    = WORD_W'(prod >> lowpos);
    return base_tab[idx] + lin + q;
  endfunction

  always @(posedge clk_i) begin
    logic [WORD_W-1:0] want;
    if (rst_ni) begin
      if (m_tvalid_i && m_tready_i) begin
        if (roots_q.size() == 0) begin
          $display("%0t: root word %h arrived with none expected", $time, m_tdata_i);
          fails++;
        end else begin
          want = roots_q.pop_front();
          checked++;
          if (m_tdata_i !== want) begin
            $display("%0t: root mismatch, expected %h, got %h", $time, want, m_tdata_i);
            fails++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (tqsa_pkg::req_e'(s_tuser_i[0]) == tqsa_pkg::REQ_WRITE) begin
          base_tab[s_tdata_i[33:25]]  = s_tdata_i[65:34];
          slope_tab[s_tdata_i[33:25]] = s_tdata_i[97:66];
          curve_tab[s_tdata_i[33:25]] = s_tdata_i[105:98];
        end else begin
          roots_q.push_back(predict_root(s_tdata_i[OPERAND_W-1:0]));
        end
      end
    end
    fail_count_o    <= fails;
    roots_due_o     <= roots_q.size();
    roots_checked_o <= checked;
  end

endmodule

// File: sim/tb_table_quadratic_sqrt_approx.sv
// Testbench top for the square root block: stimulus, output back-pressure and verdict.
`timescale 1ns / 100ps

module tb_table_quadratic_sqrt_approx;

  localparam int unsigned IN_TDATA_W  = tqsa_pkg::IN_TDATA_W;
  localparam int unsigned OUT_TDATA_W = tqsa_pkg::OUT_TDATA_W;
  localparam int unsigned STORE_DEPTH = tqsa_pkg::STORE_DEPTH;
  localparam int unsigned ADDR_W      = tqsa_pkg::ADDR_W;
  localparam int unsigned WORD_W      = tqsa_pkg::WORD_W;
  localparam int unsigned CURVE_W     = tqsa_pkg::CURVE_W;
  localparam int unsigned OPERAND_W   = tqsa_pkg::OPERAND_W;
  localparam int unsigned LOW_W       = tqsa_pkg::LOW_W;
  localparam int unsigned LOW_BITS    = tqsa_pkg::LOW_BITS;
  localparam int unsigned INDEX_BITS  = tqsa_pkg::INDEX_BITS;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 400;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [0:0]             s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int unsigned fail_count;
  int unsigned roots_due;
  int unsigned roots_checked;

  int unsigned rx_stall_pct = 0;
  int unsigned tx_idle_pct  = 0;
  bit          hold_armed   = 1'b0;
  bit          hold_taken   = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned quiet_cycles = 0;

  int unsigned words_sent  = 0;
  int unsigned writes_sent = 0;
  bit          entry_written [STORE_DEPTH];
  int unsigned written_q [$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  table_quadratic_sqrt_approx i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  tqsa_root_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_tvalid_i      (s_tvalid),
    .s_tready_i      (s_tready),
    .s_tdata_i       (s_tdata),
    .s_tuser_i       (s_tuser),
    .m_tvalid_i      (m_tvalid),
    .m_tready_i      (m_tready),
    .m_tdata_i       (m_tdata),
    .fail_count_o    (fail_count),
    .roots_due_o     (roots_due),
    .roots_checked_o (roots_checked)
  );

  // output side: random stalls, plus one long hold-off so the pipe fills up
  always @(posedge clk_i) begin
    if (hold_armed && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      m_tready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("table_quadratic_sqrt_approx verification failed");
      $finish;
    end
  end

  task automatic send_word(input tqsa_pkg::req_e req, input logic [IN_TDATA_W-1:0] word);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= req;
    do @(posedge clk_i); while (!s_tready);
    words_sent++;
  endtask

  task automatic write_entry(input logic [ADDR_W-1:0] e, input logic [WORD_W-1:0] b,
                             input logic [WORD_W-1:0] s, input logic [CURVE_W-1:0] c);
    logic [OPERAND_W-1:0] junk;
    junk = OPERAND_W'($urandom);
    send_word(tqsa_pkg::REQ_WRITE, {6'b0, c, s, b, e, junk});
    writes_sent++;
    if (!entry_written[e]) begin
      entry_written[e] = 1'b1;
      written_q.push_back(e);
    end
  endtask

  task automatic ask_root(input logic [OPERAND_W-1:0] x);
    logic [IN_TDATA_W-1:0] word;
    word = IN_TDATA_W'({$urandom, $urandom, $urandom, $urandom});
    word[IN_TDATA_W-1:106] = '0;
    word[OPERAND_W-1:0]    = x;
    send_word(tqsa_pkg::REQ_ROOT, word);
  endtask

  task automatic random_write();
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] s;
    b = $urandom;
    s = $urandom;
    case ($urandom_range(9))
      0: b = '0;
      1: b = '1;
      2: s = '0;
      3: s = '1;
      default: ;
    endcase
    write_entry(ADDR_W'($urandom), b, s, CURVE_W'($urandom));
  endtask

  // operand aimed at an entry already loaded; low field sometimes at its extremes
  task automatic random_root();
    logic [ADDR_W-1:0]    e;
    logic [LOW_W-1:0]     low;
    logic                 unit_bit;
    logic [OPERAND_W-1:0] x;
    e        = ADDR_W'(written_q[$urandom_range(written_q.size() - 1)]);
    low      = LOW_W'($urandom);
    unit_bit = 1'($urandom_range(1));
    case ($urandom_range(7))
      0: low = '0;
      1: low = '1;
      default: ;
    endcase
    if (e[ADDR_W-1])
      x = {1'b1, e[INDEX_BITS-1:0], low};
    else
      x = {1'b0, unit_bit, e[INDEX_BITS-1:0], low[LOW_BITS-1:0]};
    ask_root(x);
  endtask

  initial begin
    int unsigned tx_pct [4];
    int unsigned rx_pct [4];
    tx_pct = '{0, 65, 0, 31};
    rx_pct = '{0, 0, 65, 31};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: corner entries, extreme words, low field and u at both ends
    write_entry(9'd0,   32'h0000_0000, 32'hFFFF_FFFF, 8'hFF);
    write_entry(9'd511, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    write_entry(9'd255, 32'h3504_F334, 32'h0000_0001, 8'h00);
    write_entry(9'd256, 32'h0B50_4F33, 32'h1234_5678, 8'h80);
    ask_root(25'h000_0000);
    ask_root(25'h080_0000);
    ask_root(25'h080_4000);
    ask_root(25'h080_7FFF);
    ask_root(25'h0FF_FFFF);
    ask_root(25'h07F_FFFF);  // below one
    ask_root(25'h100_0000);
    ask_root(25'h1FF_FFFF);
    ask_root(25'h1FF_7FC0);
    // rewrite then read straight away
    write_entry(9'd0,   32'h8000_0000, 32'h0000_0001, 8'h01);
    ask_root(25'h080_7FFF);
    write_entry(9'd256, 32'hFFFF_FFFF, 32'h8000_0000, 8'hFF);
    ask_root(25'h100_FFFF);

    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct = tx_pct[ph];
      rx_stall_pct <= rx_pct[ph];
      if (ph == 0)
        hold_armed <= 1'b1;
      for (int n = 0; n < 358; n++) begin
        if ($urandom_range(99) < 25)
          random_write();
        else
          random_root();
      end
    end

    s_tvalid <= 1'b0;
    // let the count catch up with the last accepted word
    @(posedge clk_i);
    while (roots_due != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("%0d words sent: %0d table writes, %0d roots checked, %0d entries loaded",
             words_sent, writes_sent, roots_checked, written_q.size());
    $display("idling on each side in turn, and one long output hold-off under full load");
    if (fail_count == 0 && roots_due == 0) begin
      $display("table_quadratic_sqrt_approx verification clean");
    end else begin
      $display("table_quadratic_sqrt_approx verification failed");
    end
    $finish;
  end

endmodule
